### rtl/prba_pkg.sv
// Shared widths, codes and types of the partitioned region bump allocator.
`timescale 1ns / 1ps

package prba_pkg;

  localparam int CNT_W     = 21;  // slot counts, sizes, cursors
  localparam int SLOT_W    = 20;  // returned slot index
  localparam int CMD_W     = 1;
  localparam int FRAME_W   = 3;
  localparam int WORKER_W  = 4;
  localparam int WC_W      = 4;   // worker_count register
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;
  localparam int DVR_W     = 4;   // divisor width of the sizing divider

  localparam logic [CNT_W-1:0] HEAP_LIMIT = 21'h100000;

  localparam logic [CMD_W-1:0] CMD_ALLOC       = 1'b0;
  localparam logic [CMD_W-1:0] CMD_RESET_FRAME = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEAP_SIZE    = 2'd0,
    REG_WORKER_COUNT = 2'd1,
    REG_RESERVED     = 2'd2
  } cfg_reg_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_REJECT    = 2'd1,
    STATUS_EXHAUSTED = 2'd2
  } status_e;

  // Derived configuration seen by the request path.
  typedef struct packed {
    logic             busy;
    logic             flush;
    logic             config_ok;
    logic [WC_W-1:0]  worker_count;
    logic [CNT_W-1:0] region_size;
  } cfg_t;

  // Cursor store update from the request stage.
  typedef struct packed {
    logic                wr_en;
    logic                clr_en;
    logic [FRAME_W-1:0]  frame;
    logic [WORKER_W-1:0] worker;
    logic [CNT_W-1:0]    data;
  } cur_upd_t;

endpackage

### rtl/prba_req_if.sv
// Request channel: valid/ready handshake with the allocate or reset-frame item.
`timescale 1ns / 1ps

interface prba_req_if;
  import prba_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [FRAME_W-1:0]  frame_slot;
  logic [WORKER_W-1:0] worker;
  logic [CNT_W-1:0]    count;

  modport source (output valid, cmd, frame_slot, worker, count, input ready);
  modport sink   (input valid, cmd, frame_slot, worker, count, output ready);
endinterface

### rtl/prba_rsp_if.sv
// Response channel: valid/ready handshake with status and first slot.
`timescale 1ns / 1ps

interface prba_rsp_if;
  import prba_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   first_slot;

  modport source (output valid, status, first_slot, input ready);
  modport sink   (input valid, status, first_slot, output ready);
endinterface

### rtl/partitioned_region_bump_allocator_unit.sv
// Top level of the partitioned region bump allocator.
`timescale 1ns / 1ps

// Slot allocator over a heap cut into FRAME_SLOTS sections, each holding a
// reserved head and one region per worker with its own bump cursor.
// Channels: req_i carries items (cmd, frame_slot, worker, count); rsp_o
// returns one item per request (status, first_slot). Both use valid/ready;
// an item moves on a clock edge where both are high.
// Configuration: cfg_we_i/cfg_idx_i/cfg_wdata_i write heap_size,
// worker_count and reserved_per_section. Every write to one of these three
// clears all cursors and re-derives the section size (reciprocal multiply)
// and the region size (one-bit-per-cycle divider) plus a table fill;
// req_i.ready stays low from a valid configuration write until the table
// fill is done (it rises earlier when the write is rejected early).
// Throughput: one item per cycle while rsp_o.ready is high and no sizing runs;
// items pass the input stage (registered cursor read), then the result register.
// Back-to-back requests to the same region see the updated cursor through
// forwarding around the cursor memory.
// Stall: the result register holds while rsp_o.ready is low; one more item
// waits in the input stage, then req_i.ready drops.
// Reset: all cursors read as zero, the block is unconfigured and answers
// every request with status rejected until a valid configuration is written.

module partitioned_region_bump_allocator_unit #(
  parameter int FRAME_SLOTS = 4,
  parameter int MAX_WORKERS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [prba_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [prba_pkg::CNT_W-1:0]     cfg_wdata_i,
  prba_req_if.sink                       req_i,
  prba_rsp_if.source                     rsp_o
);
  import prba_pkg::*;

  localparam logic [FRAME_W:0] FRAME_LIMIT = (FRAME_W + 1)'(FRAME_SLOTS);

  cfg_t                cfg;
  cur_upd_t            upd;
  logic [CNT_W-1:0]    frame_base, worker_off, cur;

  // input stage
  logic                s1_valid_q;
  logic [CMD_W-1:0]    s1_cmd_q;
  logic [FRAME_W-1:0]  s1_frame_q;
  logic [WORKER_W-1:0] s1_worker_q;
  logic [CNT_W-1:0]    s1_count_q;

  // result register
  logic                out_valid_q;
  status_e             out_status_q;
  logic [SLOT_W-1:0]   out_first_q;

  logic                in_fire, s1_fire;
  logic                bad, worker_bad, exhausted;
  logic [CNT_W-1:0]    avail;
  logic [CNT_W:0]      base_sum;
  status_e             status_d;
  logic [SLOT_W-1:0]   first_d;
  logic                wr_d, clr_d;

  assign s1_fire     = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !cfg.busy && (!s1_valid_q || s1_fire);
  assign in_fire     = req_i.valid && req_i.ready;

  prba_cfg #(
    .FRAME_SLOTS (FRAME_SLOTS),
    .MAX_WORKERS (MAX_WORKERS)
  ) u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .frame_sel_i  (s1_frame_q),
    .worker_sel_i (s1_worker_q),
    .cfg_o        (cfg),
    .frame_base_o (frame_base),
    .worker_off_o (worker_off)
  );

  prba_cursor_mem #(
    .FRAME_SLOTS (FRAME_SLOTS),
    .MAX_WORKERS (MAX_WORKERS)
  ) u_cursor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .flush_i     (cfg.flush),
    .rd_en_i     (in_fire),
    .rd_frame_i  (req_i.frame_slot),
    .rd_worker_i (req_i.worker),
    .upd_i       (upd),
    .cur_o       (cur)
  );

  // Request decode, bounds check and bump arithmetic on the staged item.
  assign bad        = !cfg.config_ok || ({1'b0, s1_frame_q} >= FRAME_LIMIT);
  assign worker_bad = (s1_worker_q >= cfg.worker_count) || (s1_count_q == '0);
  assign avail      = cfg.region_size - cur;
  assign exhausted  = (cur > cfg.region_size) || (s1_count_q > avail);
  assign base_sum   = (CNT_W + 1)'(frame_base) + (CNT_W + 1)'(worker_off) +
                      (CNT_W + 1)'(cur);

  always_comb begin
    status_d = STATUS_REJECT;
    first_d  = '0;
    wr_d     = 1'b0;
    clr_d    = 1'b0;
    if (!bad) begin
      case (s1_cmd_q)
        CMD_RESET_FRAME: begin
          status_d = STATUS_OK;
          clr_d    = 1'b1;
        end
        CMD_ALLOC: begin
          if (!worker_bad) begin
            if (exhausted) begin
              status_d = STATUS_EXHAUSTED;
            end else begin
              status_d = STATUS_OK;
              first_d  = base_sum[SLOT_W-1:0];
              wr_d     = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign upd.wr_en  = s1_fire && wr_d;
  assign upd.clr_en = s1_fire && clr_d;
  assign upd.frame  = s1_frame_q;
  assign upd.worker = s1_worker_q;
  assign upd.data   = cur + s1_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_cmd_q    <= req_i.cmd;
      s1_frame_q  <= req_i.frame_slot;
      s1_worker_q <= req_i.worker;
      s1_count_q  <= req_i.count;
    end
    if (s1_fire) begin
      out_status_q <= status_d;
      out_first_q  <= first_d;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.first_slot = out_first_q;

endmodule

### rtl/prba_cfg.sv
// Configuration registers, serial sizing divider and per-frame/per-worker base tables.
`timescale 1ns / 1ps

module prba_cfg #(
  parameter int FRAME_SLOTS = 4,
  parameter int MAX_WORKERS = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [prba_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [prba_pkg::CNT_W-1:0]         cfg_wdata_i,
  input  logic [prba_pkg::FRAME_W-1:0]       frame_sel_i,
  input  logic [prba_pkg::WORKER_W-1:0]      worker_sel_i,
  output prba_pkg::cfg_t                     cfg_o,
  output logic [prba_pkg::CNT_W-1:0]         frame_base_o,
  output logic [prba_pkg::CNT_W-1:0]         worker_off_o
);
  import prba_pkg::*;

  localparam int FW     = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
  localparam int WW     = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int TBL    = (FRAME_SLOTS > MAX_WORKERS) ? FRAME_SLOTS : MAX_WORKERS;
  localparam int KW     = $clog2(TBL + 1);
  localparam int STEP_W = $clog2(CNT_W);

  // section size by reciprocal multiply; shift of CNT_W + 3 is exact for
  // any 21-bit heap and a frame count up to 8
  localparam int DIV_SH = CNT_W + 3;
  localparam int PROD_W = DIV_SH + CNT_W;
  localparam longint unsigned SEC_RCP_V =
    ((64'd1 << DIV_SH) + 64'(FRAME_SLOTS) - 64'd1) / 64'(FRAME_SLOTS);

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CNT_W - 1);
  localparam logic [PROD_W-1:0] SEC_RCP   = PROD_W'(SEC_RCP_V);
  localparam logic [WC_W:0]     WC_MAX    = (WC_W + 1)'(MAX_WORKERS);
  localparam logic [KW-1:0]     FILL_LAST = KW'(TBL - 1);
  localparam logic [KW-1:0]     FILL_FS   = KW'(FRAME_SLOTS);
  localparam logic [KW-1:0]     FILL_MW   = KW'(MAX_WORKERS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_REG,
    ST_FILL
  } state_e;

  state_e              state_q;
  logic [CNT_W-1:0]    heap_q, res_q, sec_q, region_q;
  logic [WC_W-1:0]     wc_q;
  logic                ok_q;
  logic [STEP_W-1:0]   step_q;
  logic [DVR_W-1:0]    rem_q, dvr_q;
  logic [CNT_W-1:0]    quo_q, dvd_q;
  logic [CNT_W-1:0]    facc_q, wacc_q;
  logic [KW-1:0]       fill_q;

  logic [CNT_W-1:0]    frame_base_q [FRAME_SLOTS];
  logic [CNT_W-1:0]    worker_off_q [MAX_WORKERS];

  logic [DVR_W:0]      rem_sh;
  logic                ge;
  logic [DVR_W-1:0]    rem_nx;
  logic [CNT_W-1:0]    quo_nx;
  logic [PROD_W-1:0]   sec_prod;
  logic [CNT_W-1:0]    sec_nx;
  logic                heap_ok, wc_ok, sec_ok, flush;

  // one quotient bit per cycle, restoring
  always_comb begin
    rem_sh = {rem_q, dvd_q[CNT_W-1]};
    ge     = rem_sh >= {1'b0, dvr_q};
    rem_nx = ge ? DVR_W'(rem_sh - {1'b0, dvr_q}) : rem_sh[DVR_W-1:0];
    quo_nx = {quo_q[CNT_W-2:0], ge};
  end

  assign sec_prod = PROD_W'(heap_q) * SEC_RCP;
  assign sec_nx   = sec_prod[PROD_W-1:DIV_SH];

  assign heap_ok = (heap_q != '0) && (heap_q <= HEAP_LIMIT);
  assign wc_ok   = (wc_q != '0) && ({1'b0, wc_q} <= WC_MAX);
  assign sec_ok  = (sec_nx != '0) && (res_q < sec_nx);
  assign flush   = cfg_we_i && ((cfg_idx_i == REG_HEAP_SIZE) ||
                                (cfg_idx_i == REG_WORKER_COUNT) ||
                                (cfg_idx_i == REG_RESERVED));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      heap_q   <= '0;
      wc_q     <= WC_W'(1);
      res_q    <= '0;
      sec_q    <= '0;
      region_q <= '0;
      ok_q     <= 1'b0;
      step_q   <= '0;
      rem_q    <= '0;
      dvr_q    <= '0;
      quo_q    <= '0;
      dvd_q    <= '0;
      facc_q   <= '0;
      wacc_q   <= '0;
      fill_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_HEAP_SIZE:    heap_q <= cfg_wdata_i;
        REG_WORKER_COUNT: wc_q   <= cfg_wdata_i[WC_W-1:0];
        REG_RESERVED:     res_q  <= cfg_wdata_i;
        default: ;
      endcase
      if (flush) begin
        ok_q    <= 1'b0;
        state_q <= ST_CHECK;
      end
    end else begin
      case (state_q)
        ST_CHECK: begin
          region_q <= '0;
          if (heap_ok && wc_ok && sec_ok) begin
            sec_q   <= sec_nx;
            dvd_q   <= sec_nx - res_q;
            dvr_q   <= wc_q;
            rem_q   <= '0;
            quo_q   <= '0;
            step_q  <= '0;
            state_q <= ST_DIV_REG;
          end else begin
            sec_q   <= '0;
            state_q <= ST_IDLE;
          end
        end
        ST_DIV_REG: begin
          rem_q  <= rem_nx;
          quo_q  <= quo_nx;
          dvd_q  <= dvd_q << 1;
          step_q <= step_q + STEP_W'(1);
          if (step_q == LAST_STEP) begin
            if (quo_nx != '0) begin
              region_q <= quo_nx;
              facc_q   <= res_q;
              wacc_q   <= '0;
              fill_q   <= '0;
              state_q  <= ST_FILL;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        ST_FILL: begin
          facc_q <= facc_q + sec_q;
          wacc_q <= wacc_q + region_q;
          fill_q <= fill_q + KW'(1);
          if (fill_q == FILL_LAST) begin
            ok_q    <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // frame base = frame * section + reserved; worker offset = worker * region
  always_ff @(posedge clk_i) begin
    if (state_q == ST_FILL) begin
      if (fill_q < FILL_FS) frame_base_q[fill_q[FW-1:0]] <= facc_q;
      if (fill_q < FILL_MW) worker_off_q[fill_q[WW-1:0]] <= wacc_q;
    end
  end

  assign frame_base_o = frame_base_q[frame_sel_i[FW-1:0]];
  assign worker_off_o = worker_off_q[worker_sel_i[WW-1:0]];

  assign cfg_o.busy         = (state_q != ST_IDLE);
  assign cfg_o.flush        = flush;
  assign cfg_o.config_ok    = ok_q;
  assign cfg_o.worker_count = wc_q;
  assign cfg_o.region_size  = region_q;

endmodule

### rtl/prba_cursor_mem.sv
// Bump cursor memory with per-entry valid bits and write/clear forwarding.
`timescale 1ns / 1ps

module prba_cursor_mem #(
  parameter int FRAME_SLOTS = 4,
  parameter int MAX_WORKERS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          flush_i,
  input  logic                          rd_en_i,
  input  logic [prba_pkg::FRAME_W-1:0]  rd_frame_i,
  input  logic [prba_pkg::WORKER_W-1:0] rd_worker_i,
  input  prba_pkg::cur_upd_t            upd_i,
  output logic [prba_pkg::CNT_W-1:0]    cur_o
);
  import prba_pkg::*;

  localparam int DEPTH = FRAME_SLOTS * MAX_WORKERS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  function automatic logic [AW-1:0] entry_idx(input logic [FRAME_W-1:0]  f,
                                              input logic [WORKER_W-1:0] w);
    logic [31:0] flat;
    flat = 32'(f) * 32'(MAX_WORKERS) + 32'(w);
    return flat[AW-1:0];
  endfunction

  logic [CNT_W-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [CNT_W-1:0] rd_data_q, fwd_q;
  logic             rd_valid_q, wr_hit_q, clr_hit_q;
  logic [AW-1:0]    rd_idx, wr_idx;
  logic             wr_hit, clr_hit;

  assign rd_idx  = entry_idx(rd_frame_i, rd_worker_i);
  assign wr_idx  = entry_idx(upd_i.frame, upd_i.worker);
  // same-edge update of the entry being read: memory returns the old value
  assign wr_hit  = upd_i.wr_en && (upd_i.frame == rd_frame_i) &&
                   (upd_i.worker == rd_worker_i);
  assign clr_hit = upd_i.clr_en && (upd_i.frame == rd_frame_i);

  always_ff @(posedge clk_i) begin
    if (upd_i.wr_en) mem_q[wr_idx] <= upd_i.data;
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_idx];
      fwd_q     <= upd_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      wr_hit_q   <= 1'b0;
      clr_hit_q  <= 1'b0;
    end else begin
      if (flush_i) begin
        valid_q <= '0;
      end else begin
        if (upd_i.clr_en) begin
          for (int w = 0; w < MAX_WORKERS; w++) begin
            valid_q[entry_idx(upd_i.frame, WORKER_W'(w))] <= 1'b0;
          end
        end
        if (upd_i.wr_en) valid_q[wr_idx] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_idx];
        wr_hit_q   <= wr_hit;
        clr_hit_q  <= clr_hit;
      end
    end
  end

  assign cur_o = clr_hit_q  ? '0 :
                 wr_hit_q   ? fwd_q :
                 rd_valid_q ? rd_data_q : '0;

endmodule

### rtl/prba_checker.sv
// Port-level assertions for the allocator top level, with its bind.
`timescale 1ns / 1ps

module prba_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_we_i,
  input logic [prba_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input logic                           req_valid_i,
  input logic                           req_ready_i,
  input logic                           rsp_valid_i,
  input logic                           rsp_ready_i,
  input logic [prba_pkg::STATUS_W-1:0]  rsp_status_i,
  input logic [prba_pkg::SLOT_W-1:0]    rsp_first_slot_i
);
  import prba_pkg::*;

  // a held result keeps its payload
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i) &&
                                    $stable(rsp_first_slot_i))
    else $error("response changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_status_i == STATUS_OK) || (rsp_status_i == STATUS_REJECT) ||
                    (rsp_status_i == STATUS_EXHAUSTED))
    else $error("undefined status code");

  a_fail_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i != STATUS_OK) |-> (rsp_first_slot_i == '0))
    else $error("failed request returned a nonzero slot");

  // resizing after a register write blocks new requests
  a_cfg_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && ((cfg_idx_i == REG_HEAP_SIZE) || (cfg_idx_i == REG_WORKER_COUNT) ||
                 (cfg_idx_i == REG_RESERVED)) |=> !req_ready_i)
    else $error("request accepted during resize");

  // a fresh result follows an accepted request through the input stage
  a_rsp_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> $past(req_valid_i && req_ready_i, 2))
    else $error("response without matching request");

endmodule

bind partitioned_region_bump_allocator_unit prba_checker u_prba_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .cfg_we_i         (cfg_we_i),
  .cfg_idx_i        (cfg_idx_i),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_status_i     (rsp_o.status),
  .rsp_first_slot_i (rsp_o.first_slot)
);

### sim/prba_alloc_checker.sv
// Checker for the bump allocator: predicts every grant from the request stream and compares.
`timescale 1ns / 1ps

module prba_alloc_checker #(
  parameter int FRAME_SLOTS = 4,
  parameter int MAX_WORKERS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [prba_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [prba_pkg::CNT_W-1:0]     cfg_wdata_i,
  prba_req_if                            req_i,
  prba_rsp_if                            rsp_i,
  output int                             mismatches_o,
  output int                             owed_o
);
  import prba_pkg::*;

  localparam int DEPTH = FRAME_SLOTS * MAX_WORKERS;

  typedef struct packed {
    status_e           status;
    logic [SLOT_W-1:0] first_slot;
  } grant_t;

  logic [CNT_W-1:0] heap_size;
  logic [WC_W-1:0]  workers;
  logic [CNT_W-1:0] reserved;
  logic [CNT_W-1:0] sec_size;
  logic [CNT_W-1:0] region_size;
  logic             sizing_ok;
  logic [CNT_W-1:0] cursor [DEPTH];

  grant_t grants_due[$];
  grant_t want;
  int     mismatches;

  // A write to any of the three sizing registers re-derives the sizes and empties every region.
  function automatic void resize();
    int unsigned sec;
    int unsigned region;
    for (int i = 0; i < DEPTH; i++) cursor[i] = '0;
    sizing_ok   = 1'b0;
    sec_size    = '0;
    region_size = '0;
    if (heap_size == 0 || heap_size > HEAP_LIMIT) return;
    if (workers == 0 || workers > MAX_WORKERS) return;
    sec = heap_size / FRAME_SLOTS;
    if (sec == 0 || reserved >= sec) return;
    region = (sec - reserved) / workers;
    if (region == 0) return;
    sec_size    = CNT_W'(sec);
    region_size = CNT_W'(region);
    sizing_ok   = 1'b1;
  endfunction

  function automatic void write_register(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] data);
    case (idx)
      REG_HEAP_SIZE:    heap_size = data;
      REG_WORKER_COUNT: workers   = data[WC_W-1:0];
      REG_RESERVED:     reserved  = data;
      default:          return;
    endcase
    resize();
  endfunction

  function automatic grant_t serve_request(logic [CMD_W-1:0] cmd, logic [FRAME_W-1:0] frame,
                                           logic [WORKER_W-1:0] worker, logic [CNT_W-1:0] count);
    grant_t      g;
    int unsigned idx;
    int unsigned cur;
    int unsigned base;
    g.status     = STATUS_REJECT;
    g.first_slot = '0;
    if (!sizing_ok || frame >= FRAME_SLOTS) return g;
    if (cmd == CMD_RESET_FRAME) begin
      for (int w = 0; w < workers && w < MAX_WORKERS; w++) cursor[frame * MAX_WORKERS + w] = '0;
      g.status = STATUS_OK;
      return g;
    end
    if (worker >= workers || worker >= MAX_WORKERS || count == 0) return g;
    idx = frame * MAX_WORKERS + worker;
    cur = cursor[idx];
    if (cur > region_size || count > region_size - cur) begin
      g.status = STATUS_EXHAUSTED;
      return g;
    end
    base         = frame * sec_size + reserved + worker * region_size;
    cursor[idx]  = CNT_W'(cur + count);
    g.status     = STATUS_OK;
    g.first_slot = SLOT_W'(base + cur);
    return g;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_size  = '0;
      workers    = WC_W'(1);
      reserved   = '0;
      resize();
      grants_due.delete();
      mismatches = 0;
    end else begin
      if (cfg_we_i) write_register(cfg_idx_i, cfg_wdata_i);
      if (rsp_i.valid && rsp_i.ready) begin
        if (grants_due.size() == 0) begin
          mismatches++;
          $display("%0t ns: unexpected item, expected none, actual status %0d first_slot %0d",
                   $time, rsp_i.status, rsp_i.first_slot);
        end else begin
          want = grants_due.pop_front();
          if (rsp_i.status !== want.status) begin
            mismatches++;
            $display("%0t ns: status mismatch, expected %0d, actual %0d",
                     $time, want.status, rsp_i.status);
          end
          if (rsp_i.first_slot !== want.first_slot) begin
            mismatches++;
            $display("%0t ns: first_slot mismatch, expected %0d, actual %0d",
                     $time, want.first_slot, rsp_i.first_slot);
          end
        end
      end
      if (req_i.valid && req_i.ready)
        grants_due.push_back(serve_request(req_i.cmd, req_i.frame_slot, req_i.worker,
                                           req_i.count));
    end
    mismatches_o <= mismatches;
    owed_o       <= grants_due.size();
  end

endmodule

### sim/tb_partitioned_region_bump_allocator_unit.sv
// Testbench top: directed and random allocate/reset-frame traffic over many heap sizings.
`timescale 1ns / 1ps

// The checker beside the block predicts every grant; this module only makes
// stimulus and gives the verdict. Sizing registers are rewritten only once
// every outstanding item has come back, then the block gets time to rerun its
// divider before requests flow again (it also holds req ready low meanwhile).

module tb_partitioned_region_bump_allocator_unit;
  import prba_pkg::*;

  localparam int FRAME_SLOTS   = 4;
  localparam int MAX_WORKERS   = 8;
  localparam int RESET_CYCLES  = 12;
  // Settle time covers the check, the divider and the table fill.
  localparam int SIZING_SETTLE = 64;
  localparam int DRAIN_CYCLES  = 8;
  // Longest legal quiet stretch is a sizing pass or a long random stall.
  localparam int QUIET_LIMIT   = 4000;
  localparam int VALID_PHASES  = 12;
  localparam int PHASE_ITEMS   = 130;
  localparam int BAD_ITEMS     = 6;
  localparam int NUM_BAD       = 10;

  // Index 3 decodes to no register; a write there must leave state alone.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned          CNT_MAX    = (1 << CNT_W) - 1;

  // Sizings the block must refuse: {heap_size, worker_count, reserved}.
  localparam int unsigned BAD_SIZING [NUM_BAD][3] = '{
    '{0,          4,  0},        // empty heap
    '{1048577,    4,  0},        // heap just over the limit
    '{CNT_MAX,    4,  0},        // heap at field max
    '{4096,       0,  0},        // no workers
    '{4096,       9,  0},        // one worker too many
    '{4096,       15, 0},        // worker field max
    '{400,        2,  100},      // reserved equals section size
    '{4096,       1,  CNT_MAX},  // reserved at field max
    '{28,         8,  0},        // regions round down to zero
    '{3,          1,  0}         // sections round down to zero
  };

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CNT_W-1:0]     cfg_wdata;
  int                   mismatches;
  int                   owed;

  // Idle percentages of the sender and the receiver for the current phase.
  int send_idle_pct = 0;
  int rsp_stall_pct = 0;

  // Shadow of what was written, only to steer counts and workers.
  int unsigned set_workers = 1;
  int unsigned region_hint = 1;

  prba_req_if req_bus ();
  prba_rsp_if rsp_bus ();

  partitioned_region_bump_allocator_unit #(
    .FRAME_SLOTS (FRAME_SLOTS),
    .MAX_WORKERS (MAX_WORKERS)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_bus),
    .rsp_o       (rsp_bus)
  );

  prba_alloc_checker #(
    .FRAME_SLOTS (FRAME_SLOTS),
    .MAX_WORKERS (MAX_WORKERS)
  ) grant_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .req_i        (req_bus),
    .rsp_i        (rsp_bus),
    .mismatches_o (mismatches),
    .owed_o       (owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver back-pressure, redrawn every cycle.
  initial begin
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  // Watchdog: any handshake or register write counts as progress.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || cfg_we)
        quiet = 0;
      else
        quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // One request item: optional idle gap, then hold valid until taken.
  task automatic issue(input logic [CMD_W-1:0] cmd, input int unsigned frame,
                       input int unsigned worker, input int unsigned count);
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid      <= 1'b1;
    req_bus.cmd        <= cmd;
    req_bus.frame_slot <= FRAME_W'(frame);
    req_bus.worker     <= WORKER_W'(worker);
    req_bus.count      <= CNT_W'(count);
    do @(posedge clk); while (!req_bus.ready);
  endtask

  task automatic alloc(input int unsigned frame, input int unsigned worker,
                       input int unsigned count);
    issue(CMD_ALLOC, frame, worker, count);
  endtask

  // Stop sending and wait until every outstanding item has come back.
  task automatic wait_drained();
    req_bus.valid <= 1'b0;
    do @(posedge clk); while (owed != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= CNT_W'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
    repeat (SIZING_SETTLE) @(posedge clk);
  endtask

  task automatic set_sizing(input int unsigned heap, input int unsigned workers,
                            input int unsigned reserved);
    int unsigned w;
    int unsigned sec;
    write_reg(REG_HEAP_SIZE, heap);
    write_reg(REG_WORKER_COUNT, workers);
    write_reg(REG_RESERVED, reserved);
    w           = workers & 4'hF;
    sec         = (heap & CNT_MAX) / FRAME_SLOTS;
    set_workers = w;
    region_hint = 1;
    if (w != 0 && w <= MAX_WORKERS && heap <= 1048576 && (reserved & CNT_MAX) < sec &&
        (sec - (reserved & CNT_MAX)) / w != 0)
      region_hint = (sec - (reserved & CNT_MAX)) / w;
  endtask

  task automatic set_idling(input int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
      1: begin send_idle_pct = 81; rsp_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  rsp_stall_pct = 81; end
      default: begin send_idle_pct = 28; rsp_stall_pct = 28; end
    endcase
  endtask

  // Mostly well-formed allocations sized against the region, with some
  // frame resets, out-of-range indexes, zero and oversized counts mixed in.
  task automatic random_item();
    int unsigned frame;
    int unsigned worker;
    int unsigned count;
    int unsigned roll;
    frame = ($urandom_range(9) == 0) ? $urandom_range(7, FRAME_SLOTS)
                                     : $urandom_range(FRAME_SLOTS - 1, 0);
    if ($urandom_range(99) < 8) begin
      issue(CMD_RESET_FRAME, frame, $urandom_range(15, 0), $urandom_range(CNT_MAX, 0));
    end else begin
      if (set_workers == 0 || set_workers > MAX_WORKERS || $urandom_range(9) == 0)
        worker = $urandom_range(15, 0);
      else
        worker = $urandom_range(set_workers - 1, 0);
      roll = $urandom_range(99);
      if (roll < 3)
        count = 0;
      else if (roll < 7)
        count = $urandom_range(CNT_MAX, 0);
      else if (roll < 12)
        count = region_hint + $urandom_range(1, 0);   // exact fill or one past
      else
        count = $urandom_range((region_hint / 3 > 1) ? region_hint / 3 : 1, 1);
      alloc(frame, worker, count);
    end
  endtask

  initial begin
    int unsigned heap;
    int unsigned wc;
    int unsigned sec;
    int unsigned res;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_idx            <= '0;
    cfg_wdata          <= '0;
    req_bus.valid      <= 1'b0;
    req_bus.cmd        <= CMD_ALLOC;
    req_bus.frame_slot <= '0;
    req_bus.worker     <= '0;
    req_bus.count      <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fresh out of reset nothing is configured: both commands are refused.
    alloc(0, 0, 1);
    issue(CMD_RESET_FRAME, 0, 0, 0);

    // Largest heap, most workers; the worker write carries junk above bit 3.
    set_sizing(1048576, 21'h1FFFF8, 0);   // section 262144, region 32768
    alloc(0, 0, 1);
    alloc(3, 7, 32767);
    alloc(3, 7, 1);                       // top slot of the heap
    alloc(3, 7, 1);                       // region full
    alloc(0, 0, 0);                       // zero count
    alloc(4, 0, 1);                       // frame out of range
    alloc(7, 3, 1);
    alloc(1, 8, 1);                       // worker out of range
    alloc(1, 15, 1);
    alloc(1, 1, CNT_MAX);                 // far larger than the region
    alloc(2, 2, 32768);                   // exact fill
    alloc(2, 2, 1);
    issue(CMD_RESET_FRAME, 3, 0, 0);
    issue(CMD_RESET_FRAME, 7, 15, CNT_MAX);  // bad frame on reset
    alloc(3, 7, 1);                       // frame 3 starts over
    alloc(0, 0, 1);                       // other frames keep their cursors
    write_reg(REG_UNUSED, CNT_MAX);       // no register there: nothing cleared
    alloc(0, 0, 1);

    // Smallest valid heap: one slot per section, one slot per region.
    set_sizing(4, 1, 0);
    alloc(0, 0, 1);
    alloc(0, 0, 1);
    alloc(3, 0, 1);

    // Reserved area leaves a single slot per section.
    set_sizing(1048576, 1, 262143);
    alloc(3, 0, 1);
    alloc(3, 0, 1);

    // Refused sizings: every item must come back rejected.
    for (int b = 0; b < NUM_BAD; b++) begin
      set_idling(b);
      set_sizing(BAD_SIZING[b][0], BAD_SIZING[b][1], BAD_SIZING[b][2]);
      repeat (BAD_ITEMS) random_item();
    end

    // Random valid sizings, small heaps favored so regions fill up often.
    for (int p = 0; p < VALID_PHASES; p++) begin
      set_idling(p);
      wc = $urandom_range(MAX_WORKERS, 1);
      case ($urandom_range(3, 0))
        0:       heap = $urandom_range(64, 4);
        1:       heap = $urandom_range(4096, 64);
        2:       heap = $urandom_range(1048576, 4096);
        default: heap = 1048576;
      endcase
      sec = heap / FRAME_SLOTS;
      if (sec < wc) begin
        heap = wc * FRAME_SLOTS;
        sec  = wc;
      end
      res = $urandom_range(sec - wc, 0);
      set_sizing(heap, wc, res);
      repeat (PHASE_ITEMS) random_item();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### files.f
rtl/prba_pkg.sv
rtl/prba_req_if.sv
rtl/prba_rsp_if.sv
rtl/prba_cfg.sv
rtl/prba_cursor_mem.sv
rtl/partitioned_region_bump_allocator_unit.sv
rtl/prba_checker.sv
sim/prba_alloc_checker.sv
sim/tb_partitioned_region_bump_allocator_unit.sv
